>>> design/sxyz_pkg.sv
// Shared constants for the sRGB to CIE XYZ (D65) converter: matrix coefficients,
// output field limits and the elaboration-time sRGB linearization function.
// No dependencies.
package sxyz_pkg;

   localparam int CODE_W  = 8;
   localparam int COEF_W  = 30;
   localparam int ROWS    = 3;
   localparam int X_W     = 16;
   localparam int YZ_W    = 17;

   // D65 matrix, unsigned Q0.30; rows give X, Y, Z, columns red, green, blue
   localparam logic [COEF_W-1:0] MIX_COEF [ROWS][ROWS] = '{
      '{30'd442806392, 30'd383952285, 30'd193802504},
      '{30'd228262727, 30'd767908266, 30'd77524695},
      '{30'd20720227,  30'd127972700, 30'd1020588517}
   };

   // all-ones value of each output field, carried at the widest field width
   localparam logic [YZ_W-1:0] FIELD_MAX [ROWS] = '{17'h0FFFF, 17'h1FFFF, 17'h1FFFF};

   // Linear value of one sRGB code in unsigned Q1.31; used only to build constant tables.
   function automatic logic [31:0] lin_q31(input logic [CODE_W-1:0] code);
      logic [63:0] c;
      logic [63:0] u;
      logic [63:0] s;
      logic [63:0] r;
      logic [63:0] cand;
      logic [63:0] p2;
      logic [63:0] p4;
      logic [63:0] p5;
      logic [63:0] lin;
      c = {56'd0, code};
      r = 64'd0;
      if (c <= 64'd10) begin
         lin = (c * 64'd10 * (64'd1 << 31) + 64'd16473) / 64'd32946;
      end else begin
         u = ((c * 64'd1000 + 64'd14025) << 31) / 64'd269025;
         s = (u * u + (64'd1 << 30)) >> 31;
         // bisect the fifth root of t^2, one bit per pass
         for (int b = 31; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            p2 = (cand * cand) >> 31;
            p4 = (p2 * p2) >> 31;
            p5 = (p4 * cand) >> 31;
            if (cand <= (64'd1 << 31) && p5 <= s) begin
               r = cand;
            end
         end
         lin = (s * r) >> 31;
      end
      return lin[31:0];
   endfunction

endpackage

>>> design/sxyz_lin_table.sv
// Constant 256-entry sRGB linearization table, unsigned Q1.LINEAR_FRAC_BITS.
// Entries are built at elaboration from sxyz_pkg::lin_q31; code 255 reads 1.0.
module sxyz_lin_table #(
   parameter int LINEAR_FRAC_BITS = 16
) (
   input  logic [sxyz_pkg::CODE_W-1:0] code,
   output logic [LINEAR_FRAC_BITS:0]   lin_value
);
   import sxyz_pkg::*;

   localparam int LIN_W   = LINEAR_FRAC_BITS + 1;
   localparam int DROP    = 31 - LINEAR_FRAC_BITS;
   localparam int ENTRIES = 1 << CODE_W;

   logic [LIN_W-1:0] rom [ENTRIES];

   for (genvar i = 0; i < ENTRIES; i++) begin : g_rom
      localparam logic [32:0] Q31 = {1'b0, lin_q31(CODE_W'(i))};
      // round half up to the table precision
      localparam logic [32:0] RND = (Q31 + (33'd1 << (DROP - 1))) >> DROP;
      assign rom[i] = RND[LIN_W-1:0];
   end

   assign lin_value = rom[code];

endmodule

>>> design/srgb_to_xyz_convert_unit.sv
// sRGB (8-bit codes) to CIE XYZ under D65, one pixel per clock.
// Pipeline: code register, table read, matrix products, then sum/round/saturate into the
// response register that drives rsp_tvalid and rsp_tdata.
// Throughput: one request per cycle, limited only by rsp_tready; a stage advances when
// the next has room, so bubbles close up. Reset: synchronous, clears the valid flags only.
// Depends on sxyz_pkg and sxyz_lin_table.
module srgb_to_xyz_convert_unit #(
   parameter int LINEAR_FRAC_BITS = 16,
   parameter int OUTPUT_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_code[7:0], green_code[15:8], blue_code[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // x_value[15:0], y_value[32:16], z_value[49:33], zero
);
   import sxyz_pkg::*;

   localparam int LIN_W  = LINEAR_FRAC_BITS + 1;
   localparam int PROD_W = COEF_W + LIN_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int RSH    = 30 + LINEAR_FRAC_BITS - OUTPUT_FRAC_BITS;

   // valid flags per stage
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, rsp_valid_in;
   logic ld1, ld2, ld3, ld4;

   logic [CODE_W-1:0] code_ff [ROWS];
   logic [CODE_W-1:0] code_in [ROWS];
   logic [LIN_W-1:0]  lin_ff  [ROWS];
   logic [LIN_W-1:0]  lin_in  [ROWS];
   logic [PROD_W-1:0] prod_ff [ROWS][ROWS];
   logic [PROD_W-1:0] prod_in [ROWS][ROWS];
   logic [YZ_W-1:0]   out_ff  [ROWS];
   logic [YZ_W-1:0]   out_in  [ROWS];

   // each stage loads when it is empty or its content moves on
   assign ld4 = !rsp_valid_ff || rsp_tready;
   assign ld3 = !s3_valid_ff || ld4;
   assign ld2 = !s2_valid_ff || ld3;
   assign ld1 = !s1_valid_ff || ld2;
   assign req_tready = ld1;

   assign s1_valid_in  = ld1 ? req_tvalid  : s1_valid_ff;
   assign s2_valid_in  = ld2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = ld3 ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = ld4 ? s3_valid_ff : rsp_valid_ff;

   assign code_in[0] = req_tdata[7:0];
   assign code_in[1] = req_tdata[15:8];
   assign code_in[2] = req_tdata[23:16];

   for (genvar k = 0; k < ROWS; k++) begin : g_lin
      sxyz_lin_table #(
         .LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)
      ) u_lin_table (
         .code      (code_ff[k]),
         .lin_value (lin_in[k])
      );
   end

   always_comb begin
      for (int row = 0; row < ROWS; row++) begin
         for (int col = 0; col < ROWS; col++) begin
            prod_in[row][col] = PROD_W'(MIX_COEF[row][col]) * PROD_W'(lin_ff[col]);
         end
      end
   end

   // sum one row, round half up, saturate at the field maximum
   always_comb begin
      logic [ACC_W-1:0] acc;
      logic [ACC_W-1:0] shifted;
      for (int row = 0; row < ROWS; row++) begin
         acc = ACC_W'(prod_ff[row][0]) + ACC_W'(prod_ff[row][1]) + ACC_W'(prod_ff[row][2])
               + (ACC_W'(1) << (RSH - 1));
         shifted = acc >> RSH;
         out_in[row] = (shifted > ACC_W'(FIELD_MAX[row])) ? FIELD_MAX[row]
                                                         : shifted[YZ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1 && req_tvalid) begin
         code_ff <= code_in;
      end
      if (ld2 && s1_valid_ff) begin
         lin_ff <= lin_in;
      end
      if (ld3 && s2_valid_ff) begin
         prod_ff <= prod_in;
      end
      if (ld4 && s3_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff[2], out_ff[1], out_ff[0][X_W-1:0]};

endmodule

>>> sim/srgb_to_xyz_convert_unit_tb.sv
// Self-checking testbench for srgb_to_xyz_convert_unit: drives sRGB pixels on the
// request stream and checks each XYZ response against a bit-true predictor.
// Depends on sxyz_pkg and the converter RTL.
module srgb_to_xyz_convert_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sxyz_pkg::*;

   localparam int LIN_FB      = 16;
   localparam int OUT_FB      = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_TAIL  = 16;
   localparam longint unsigned ONE_Q31 = 64'd1 << 31;

   typedef struct {
      logic [CODE_W-1:0] red;
      logic [CODE_W-1:0] green;
      logic [CODE_W-1:0] blue;
      logic [X_W-1:0]    x;
      logic [YZ_W-1:0]   y;
      logic [YZ_W-1:0]   z;
   } xyz_expect_type;

   class pixel_xyz_board;
      longint unsigned lin_tbl[256];
      xyz_expect_type  expected_xyz[$];
      int              mismatches;

      function new();
         mismatches = 0;
         for (int code = 0; code < 256; code++) begin
            lin_tbl[code] = round_to_lin(srgb_lin_q31(code));
         end
      endfunction

      // sRGB transfer rule in Q1.31: linear segment up to code 10, t^2.4 above it
      function automatic longint unsigned srgb_lin_q31(int unsigned code);
         longint unsigned c, u, s, r, cand, p2, p4, lin;
         c = code & 32'hFF;
         r = 0;
         if (c <= 10) begin
            lin = (c * 10 * ONE_Q31 + 16473) / 32946;
         end else begin
            u = ((c * 1000 + 14025) << 31) / 269025;
            s = (u * u + (64'd1 << 30)) >> 31;
            // fifth root of t^2, one bit per pass
            for (int bitpos = 31; bitpos >= 0; bitpos--) begin
               cand = r | (64'd1 << bitpos);
               if (cand <= ONE_Q31) begin
                  p2 = (cand * cand) >> 31;
                  p4 = (p2 * p2) >> 31;
                  if (((p4 * cand) >> 31) <= s) begin
                     r = cand;
                  end
               end
            end
            lin = (s * r) >> 31;
         end
         return lin;
      endfunction

      function automatic longint unsigned round_to_lin(longint unsigned q31);
         int sh;
         sh = 31 - LIN_FB;
         return (q31 + (64'd1 << (sh - 1))) >> sh;
      endfunction

      function automatic xyz_expect_type d65_xyz_of(logic [CODE_W-1:0] red,
                                                    logic [CODE_W-1:0] green,
                                                    logic [CODE_W-1:0] blue);
         xyz_expect_type  e;
         longint unsigned lin[3];
         longint unsigned acc, v;
         longint unsigned xyz_val[3];
         int              sh;
         sh = 30 + LIN_FB - OUT_FB;
         lin[0] = lin_tbl[red];
         lin[1] = lin_tbl[green];
         lin[2] = lin_tbl[blue];
         for (int row = 0; row < ROWS; row++) begin
            acc = 0;
            for (int col = 0; col < ROWS; col++) begin
               acc += 64'(MIX_COEF[row][col]) * lin[col];
            end
            v = (acc + (64'd1 << (sh - 1))) >> sh;
            if (v > 64'(FIELD_MAX[row])) begin
               v = 64'(FIELD_MAX[row]);
            end
            xyz_val[row] = v;
         end
         e.red   = red;
         e.green = green;
         e.blue  = blue;
         e.x     = xyz_val[0][X_W-1:0];
         e.y     = xyz_val[1][YZ_W-1:0];
         e.z     = xyz_val[2][YZ_W-1:0];
         return e;
      endfunction

      function void note_pixel(logic [CODE_W-1:0] red, logic [CODE_W-1:0] green,
                               logic [CODE_W-1:0] blue);
         expected_xyz.push_back(d65_xyz_of(red, green, blue));
      endfunction

      function int pending();
         return expected_xyz.size();
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("[%0t] xyz mismatch: %s", $realtime, what);
      endtask

      task check_xyz(logic [55:0] data);
         xyz_expect_type  e;
         logic [X_W-1:0]  got_x;
         logic [YZ_W-1:0] got_y;
         logic [YZ_W-1:0] got_z;
         logic [5:0]      got_pad;
         got_x   = data[15:0];
         got_y   = data[32:16];
         got_z   = data[49:33];
         got_pad = data[55:50];
         if (expected_xyz.size() == 0) begin
            report_mismatch($sformatf("response %h with no request pending", data));
         end else begin
            e = expected_xyz.pop_front();
            if (got_x !== e.x)
               report_mismatch($sformatf("X got %h want %h for rgb %0d,%0d,%0d",
                                         got_x, e.x, e.red, e.green, e.blue));
            if (got_y !== e.y)
               report_mismatch($sformatf("Y got %h want %h for rgb %0d,%0d,%0d",
                                         got_y, e.y, e.red, e.green, e.blue));
            if (got_z !== e.z)
               report_mismatch($sformatf("Z got %h want %h for rgb %0d,%0d,%0d",
                                         got_z, e.z, e.red, e.green, e.blue));
            if (got_pad !== 6'd0)
               report_mismatch($sformatf("pad bits %h not zero for rgb %0d,%0d,%0d",
                                         got_pad, e.red, e.green, e.blue));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = 24'd0;   // red_code[7:0], green_code[15:8], blue_code[23:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;           // x_value[15:0], y_value[32:16], z_value[49:33], zero

   bit feed_steady    = 1'b0;
   bit drain_steady   = 1'b0;
   bit drain_hold_req = 1'b0;

   pixel_xyz_board board = new();

   srgb_to_xyz_convert_unit #(
      .LINEAR_FRAC_BITS (LIN_FB),
      .OUTPUT_FRAC_BITS (OUT_FB)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offer one request; returns at the rising edge where it is accepted.
   task send_pixel(logic [CODE_W-1:0] red, logic [CODE_W-1:0] green,
                   logic [CODE_W-1:0] blue);
      int gap;
      gap = feed_steady ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {blue, green, red};
      req_tvalid = 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_pixel(red, green, blue);
   endtask

   task idle_input();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Favor the knee, both ends and single-bit codes now and then.
   function automatic logic [CODE_W-1:0] pick_code();
      logic [CODE_W-1:0] edge_codes[8] = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd12,
                                           8'd128, 8'd254, 8'd255};
      if ($urandom_range(0, 5) == 0)
         return edge_codes[$urandom_range(0, 7)];
      return CODE_W'($urandom_range(0, 255));
   endfunction

   task send_random(int count);
      for (int i = 0; i < count; i++) begin
         send_pixel(pick_code(), pick_code(), pick_code());
      end
   endtask

   task wait_drained();
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin : response_side
      int stall;
      while (reset) @(negedge clock);
      forever begin
         if (drain_hold_req) begin
            // hold off long enough for the pipeline to fill and back up
            drain_hold_req = 1'b0;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            stall = drain_steady ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
               rsp_tready = 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         board.check_xyz(rsp_tdata);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("srgb_to_xyz_convert_unit_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: black, white, primaries, the knee and single-bit codes
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd10,  8'd10,  8'd10);
      send_pixel(8'd11,  8'd11,  8'd11);
      send_pixel(8'd1,   8'd2,   8'd4);
      send_pixel(8'd8,   8'd16,  8'd32);
      send_pixel(8'd64,  8'd128, 8'd254);
      send_pixel(8'd10,  8'd11,  8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd170, 8'd85,  8'd170);
      send_pixel(8'd85,  8'd170, 8'd85);
      send_pixel(8'd254, 8'd254, 8'd254);
      send_pixel(8'd12,  8'd9,   8'd1);
      idle_input();
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         feed_steady  = (phase % 4 == 1) || (phase % 4 == 2);
         drain_steady = (phase % 4 == 1) || (phase % 4 == 3);
         send_random(150);
         if (phase % 2 == 1) begin
            idle_input();
            wait_drained();
         end
      end

      // back-pressure burst: the response side stalls while requests keep coming
      feed_steady  = 1'b1;
      drain_steady = 1'b0;
      drain_hold_req = 1'b1;
      send_random(60);
      idle_input();

      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (board.mismatches == 0)
         $display("srgb_to_xyz_convert_unit_tb: PASS");
      else
         $display("srgb_to_xyz_convert_unit_tb: FAIL");
      $finish;
   end
endmodule

>>> srgb_to_xyz_convert_unit.f
design/sxyz_pkg.sv
design/sxyz_lin_table.sv
design/srgb_to_xyz_convert_unit.sv
sim/srgb_to_xyz_convert_unit_tb.sv
